[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/core/esp_pkg.sv]
// ----------------------------------------------------------------------------
// esp_pkg
// types, constants and control codes of the eased slide point generator
// ----------------------------------------------------------------------------
package esp_pkg;

    localparam int MAX_MOVES_DEF = 62;
    localparam int FRAC_BITS_DEF = 16;
    localparam int EASE_THREE    = 3;
    localparam int EASE_TWO      = 2;
    localparam int EASE_ONE_Q12  = 4096;
    localparam int Q12_BITS      = 12;
    localparam int COORD_W       = 16;
    localparam int COEF_W        = 18;
    localparam int DUR_W         = 16;
    localparam int START_W       = 31;
    localparam int TIME_W        = 32;

    typedef enum logic [1:0] {
        ACT_DOWN = 2'd0,
        ACT_MOVE = 2'd1,
        ACT_UP   = 2'd2
    } esp_action_t;

    typedef struct packed {
        logic [START_W-1:0]        start_time_ms;
        logic signed [COORD_W-1:0] from_x;
        logic signed [COORD_W-1:0] from_y;
        logic signed [COORD_W-1:0] to_x;
        logic signed [COORD_W-1:0] to_y;
        logic [DUR_W-1:0]          slide_duration_ms;
        logic [DUR_W-1:0]          step_period_ms;
        logic signed [COORD_W-1:0] slope_start;
        logic signed [COORD_W-1:0] slope_end;
        logic                      emit_down;
        logic                      emit_up;
    } esp_cmd_t;

    typedef struct packed {
        logic [TIME_W-1:0]         event_time_ms;
        esp_action_t               action;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      last_event;
        logic                      moves_truncated;
    } esp_evt_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD_DOWN,
        OP_DIV_START,
        OP_EASE1,
        OP_EASE2,
        OP_EASE3,
        OP_INTERP_X,
        OP_INTERP_Y,
        OP_LOAD_MOVE,
        OP_LOAD_UP
    } esp_op_t;

    typedef struct packed {
        logic evt_free;
        logic move_pending;
        logic div_done;
        logic emit_down;
        logic emit_up;
    } esp_status_t;

endpackage

[rtl/core/esp_divider.sv]
// ----------------------------------------------------------------------------
// esp_divider
// restoring divider, one quotient bit per cycle, fraction of dividend/divisor
// ----------------------------------------------------------------------------
module esp_divider #(
    parameter int FRAC_BITS = 16,
    parameter int DIV_W     = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_W-1:0]     dividend,
    input  logic [DIV_W-1:0]     divisor,
    output logic [FRAC_BITS-1:0] quotient,
    output logic                 busy
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [FRAC_BITS-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;

    logic [DIV_W:0] shifted;
    logic [DIV_W:0] diff;
    logic           fits;

    always_comb
    begin
        shifted   = {rem_reg, 1'b0};
        diff      = shifted - {1'b0, divisor};
        fits      = shifted >= {1'b0, divisor};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = dividend;
            quo_next  = '0;
            cnt_next  = CNT_W'(FRAC_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            quo_next  = {quo_reg[FRAC_BITS-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = cnt_reg != CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;

endmodule

[rtl/core/esp_datapath.sv]
// ----------------------------------------------------------------------------
// esp_datapath
// command store, step timing, cubic ease, interpolation and event register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module esp_datapath #(
    parameter int MAX_MOVES = esp_pkg::MAX_MOVES_DEF,
    parameter int FRAC_BITS = esp_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  esp_pkg::esp_op_t    op,
    input  esp_pkg::esp_cmd_t   cmd,
    output esp_pkg::esp_status_t status,
    output esp_pkg::esp_evt_t   evt,
    output logic                evt_valid,
    input  logic                evt_stall
);

    import esp_pkg::*;

    localparam int CNT_W     = $clog2(MAX_MOVES + 1);
    localparam int TRUNC_W   = DUR_W + $clog2(MAX_MOVES + 2);
    localparam int EL_W      = DUR_W + 1;
    localparam int TS_W      = FRAC_BITS + 1;
    localparam int H1_W      = FRAC_BITS + 19;
    localparam int H1S_W     = H1_W - Q12_BITS;
    localparam int M2_W      = H1S_W + TS_W;
    localparam int H3_W      = FRAC_BITS + 8;
    localparam int M3_W      = H3_W + TS_W;
    localparam int PR_W      = M3_W - FRAC_BITS;
    localparam int P_W       = FRAC_BITS + 4;
    localparam int A_W       = FRAC_BITS + COORD_W + 1;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int NUM_W     = FRAC_BITS + 22;
    localparam int R_W       = NUM_W - FRAC_BITS;
    localparam int P_HI      = (1 << (FRAC_BITS + 3)) - 1;
    localparam int ROUND_ADD = (1 << FRAC_BITS) - 1;
    localparam int COORD_HI  = (1 << (COORD_W - 1)) - 1;

    esp_cmd_t                  cmd_reg, cmd_next;
    logic                      trunc_reg, trunc_next;
    logic [EL_W-1:0]           el_reg, el_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [COEF_W-1:0]  coef_b_reg, coef_b_next;
    logic signed [COEF_W-1:0]  coef_c_reg, coef_c_next;
    logic signed [H1_W-1:0]    h1_reg, h1_next;
    logic signed [H3_W-1:0]    h3_reg, h3_next;
    logic signed [P_W-1:0]     p_reg, p_next;
    logic signed [NUM_W-1:0]   num_reg, num_next;
    logic signed [COORD_W-1:0] px_reg, px_next;
    esp_evt_t                  evt_reg, evt_next;
    logic                      evt_valid_reg, evt_valid_next;

    logic [FRAC_BITS-1:0]      t_q;
    logic                      div_busy;
    logic signed [TS_W-1:0]    ts;
    logic [TRUNC_W-1:0]        cap_prod;
    logic                      move_pending;
    logic                      next_pending;
    logic [EL_W-1:0]           el_plus;
    logic [CNT_W-1:0]          cnt_plus;
    logic                      evt_free;
    logic signed [H1S_W-1:0]   h1s;
    logic signed [M2_W-1:0]    m2;
    logic signed [H3_W-1:0]    a_term;
    logic signed [M3_W-1:0]    m3;
    logic signed [PR_W-1:0]    pr;
    logic signed [COORD_W-1:0] ip_from, ip_to;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [NUM_W-1:0]   num_calc;

    function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [NUM_W-1:0] n);
        logic signed [NUM_W-1:0] adj;
        logic signed [R_W-1:0]   r;
        logic signed [COORD_W-1:0] res;
        adj = n + (n[NUM_W-1] ? NUM_W'(ROUND_ADD) : NUM_W'(0));
        r   = $signed(adj[NUM_W-1:FRAC_BITS]);
        if (r > R_W'(COORD_HI))
            res = COORD_W'(COORD_HI);
        else if (r < R_W'(-COORD_HI - 1))
            res = COORD_W'(-COORD_HI - 1);
        else
            res = COORD_W'(r);
        return res;
    endfunction

    esp_divider #(
        .FRAC_BITS (FRAC_BITS),
        .DIV_W     (DUR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (op == OP_DIV_START),
        .dividend (el_reg[DUR_W-1:0]),
        .divisor  (cmd_reg.slide_duration_ms),
        .quotient (t_q),
        .busy     (div_busy)
    );

    always_comb
    begin
        ts       = $signed({1'b0, t_q});
        cap_prod = TRUNC_W'(MAX_MOVES + 1) * TRUNC_W'(cmd.step_period_ms);
        evt_free = !evt_valid_reg || !evt_stall;

        move_pending = (cmd_reg.step_period_ms != '0)
                     && (el_reg < EL_W'(cmd_reg.slide_duration_ms))
                     && (cnt_reg < CNT_W'(MAX_MOVES));
        el_plus      = el_reg + EL_W'(cmd_reg.step_period_ms);
        cnt_plus     = cnt_reg + CNT_W'(1);
        next_pending = (el_plus < EL_W'(cmd_reg.slide_duration_ms))
                     && (cnt_plus < CNT_W'(MAX_MOVES));

        h1s    = $signed(h1_reg[H1_W-1:Q12_BITS]);
        m2     = M2_W'(h1s) * M2_W'(ts);
        a_term = H3_W'((A_W'($signed(cmd_reg.slope_start)) <<< FRAC_BITS) >>> Q12_BITS);
        m3     = M3_W'(h3_reg) * M3_W'(ts);
        pr     = $signed(m3[M3_W-1:FRAC_BITS]);

        if (op == OP_INTERP_X)
        begin
            ip_from = $signed(cmd_reg.from_x);
            ip_to   = $signed(cmd_reg.to_x);
        end
        else
        begin
            ip_from = $signed(cmd_reg.from_y);
            ip_to   = $signed(cmd_reg.to_y);
        end
        diff     = DIFF_W'(ip_to) - DIFF_W'(ip_from);
        num_calc = (NUM_W'(ip_from) <<< FRAC_BITS) + NUM_W'(diff) * NUM_W'(p_reg);
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        trunc_next     = trunc_reg;
        el_next        = el_reg;
        cnt_next       = cnt_reg;
        coef_b_next    = coef_b_reg;
        coef_c_next    = coef_c_reg;
        h1_next        = h1_reg;
        h3_next        = h3_reg;
        p_next         = p_reg;
        num_next       = num_reg;
        px_next        = px_reg;
        evt_next       = evt_reg;
        evt_valid_next = evt_valid_reg && evt_stall;

        case (op)
            OP_CAPTURE:
            begin
                cmd_next    = cmd;
                el_next     = EL_W'(cmd.step_period_ms);
                cnt_next    = '0;
                trunc_next  = (cmd.step_period_ms != '0)
                            && (cap_prod < TRUNC_W'(cmd.slide_duration_ms));
                coef_b_next = COEF_W'(EASE_THREE * EASE_ONE_Q12)
                            - (COEF_W'($signed(cmd.slope_start)) <<< 1)
                            - COEF_W'($signed(cmd.slope_end));
                coef_c_next = COEF_W'($signed(cmd.slope_start))
                            + COEF_W'($signed(cmd.slope_end))
                            - COEF_W'(EASE_TWO * EASE_ONE_Q12);
            end
            OP_LOAD_DOWN:
            begin
                evt_next.event_time_ms   = TIME_W'(cmd_reg.start_time_ms);
                evt_next.action          = ACT_DOWN;
                evt_next.point_x         = cmd_reg.from_x;
                evt_next.point_y         = cmd_reg.from_y;
                evt_next.last_event      = !move_pending && !cmd_reg.emit_up;
                evt_next.moves_truncated = trunc_reg;
                evt_valid_next           = 1'b1;
            end
            OP_EASE1:
            begin
                h1_next = H1_W'(coef_c_reg) * H1_W'(ts) + (H1_W'(coef_b_reg) <<< FRAC_BITS);
            end
            OP_EASE2:
            begin
                h3_next = $signed(m2[M2_W-1:FRAC_BITS]) + a_term;
            end
            OP_EASE3:
            begin
                if (pr > PR_W'(P_HI))
                    p_next = P_W'(P_HI);
                else if (pr < PR_W'(-P_HI - 1))
                    p_next = P_W'(-P_HI - 1);
                else
                    p_next = P_W'(pr);
            end
            OP_INTERP_X:
            begin
                num_next = num_calc;
            end
            OP_INTERP_Y:
            begin
                px_next  = round_sat(num_reg);
                num_next = num_calc;
            end
            OP_LOAD_MOVE:
            begin
                evt_next.event_time_ms   = TIME_W'(cmd_reg.start_time_ms) + TIME_W'(el_reg);
                evt_next.action          = ACT_MOVE;
                evt_next.point_x         = px_reg;
                evt_next.point_y         = round_sat(num_reg);
                evt_next.last_event      = !next_pending && !cmd_reg.emit_up;
                evt_next.moves_truncated = trunc_reg;
                evt_valid_next           = 1'b1;
                el_next                  = el_plus;
                cnt_next                 = cnt_plus;
            end
            OP_LOAD_UP:
            begin
                evt_next.event_time_ms   = TIME_W'(cmd_reg.start_time_ms)
                                         + TIME_W'(cmd_reg.slide_duration_ms);
                evt_next.action          = ACT_UP;
                evt_next.point_x         = '0;
                evt_next.point_y         = '0;
                evt_next.last_event      = 1'b1;
                evt_next.moves_truncated = trunc_reg;
                evt_valid_next           = 1'b1;
            end
            default:
            begin
                evt_valid_next = evt_valid_reg && evt_stall;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            evt_valid_reg <= evt_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        trunc_reg  <= trunc_next;
        el_reg     <= el_next;
        coef_b_reg <= coef_b_next;
        coef_c_reg <= coef_c_next;
        h1_reg     <= h1_next;
        h3_reg     <= h3_next;
        p_reg      <= p_next;
        num_reg    <= num_next;
        px_reg     <= px_next;
        evt_reg    <= evt_next;
    end

    assign status.evt_free     = evt_free;
    assign status.move_pending = move_pending;
    assign status.div_done     = !div_busy;
    assign status.emit_down    = cmd_reg.emit_down;
    assign status.emit_up      = cmd_reg.emit_up;
    assign evt                 = evt_reg;
    assign evt_valid           = evt_valid_reg;

    `ASSERT_NEXT(a_up_is_last, clk, rst_n, op == OP_LOAD_UP, evt_valid_reg && evt_reg.last_event)
    `ASSERT_IMPL(a_div_needs_move, clk, rst_n, op == OP_DIV_START, move_pending)
    `ASSERT_IMPL(a_load_has_room, clk, rst_n, op == OP_LOAD_DOWN || op == OP_LOAD_MOVE || op == OP_LOAD_UP, evt_free)
    `ASSERT_IMPL(a_move_count_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(MAX_MOVES))

endmodule

[rtl/core/esp_ctrl.sv]
// ----------------------------------------------------------------------------
// esp_ctrl
// sequencer for one slide command: down, per-move ease steps, up
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module esp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  esp_pkg::esp_status_t status,
    output esp_pkg::esp_op_t     op
);

    import esp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DOWN,
        S_CHECK,
        S_DIV,
        S_M1,
        S_M2,
        S_M3,
        S_IX,
        S_IY,
        S_MOVE,
        S_UP
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op         = OP_CAPTURE;
                    state_next = S_DOWN;
                end
            end
            S_DOWN:
            begin
                if (!status.emit_down)
                    state_next = S_CHECK;
                else if (status.evt_free)
                begin
                    op         = OP_LOAD_DOWN;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.move_pending)
                begin
                    op         = OP_DIV_START;
                    state_next = S_DIV;
                end
                else
                    state_next = S_UP;
            end
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_M1;
            end
            S_M1:
            begin
                op         = OP_EASE1;
                state_next = S_M2;
            end
            S_M2:
            begin
                op         = OP_EASE2;
                state_next = S_M3;
            end
            S_M3:
            begin
                op         = OP_EASE3;
                state_next = S_IX;
            end
            S_IX:
            begin
                op         = OP_INTERP_X;
                state_next = S_IY;
            end
            S_IY:
            begin
                op         = OP_INTERP_Y;
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                if (status.evt_free)
                begin
                    op         = OP_LOAD_MOVE;
                    state_next = S_CHECK;
                end
            end
            S_UP:
            begin
                if (!status.emit_up)
                    state_next = S_IDLE;
                else if (status.evt_free)
                begin
                    op         = OP_LOAD_UP;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign cmd_stall = state_reg != S_IDLE;

    `ASSERT_IMPL(a_ease_after_div, clk, rst_n, state_reg == S_M1, status.div_done)

endmodule

[rtl/core/eased_slide_point_generator_unit.sv]
// a command is captured in the idle state; its down event is loaded in the down state
// each move runs the bit-serial divider for t, then the ease, interpolation and move-load steps
// commands are taken one at a time
// output waits in the event register while stalled; the next step runs behind it
// reset: asynchronous, clears sequencer state, event valid and the divider
// ----------------------------------------------------------------------------
// eased_slide_point_generator_unit
// turns a slide command into down, eased move and up events
// ----------------------------------------------------------------------------
module eased_slide_point_generator_unit #(
    parameter int MAX_MOVES = esp_pkg::MAX_MOVES_DEF,
    parameter int FRAC_BITS = esp_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  esp_pkg::esp_cmd_t cmd,
    output logic              evt_valid,
    input  logic              evt_stall,
    output esp_pkg::esp_evt_t evt
);

    import esp_pkg::*;

    esp_op_t     op;
    esp_status_t status;

    esp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .status    (status),
        .op        (op)
    );

    esp_datapath #(
        .MAX_MOVES (MAX_MOVES),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .cmd       (cmd),
        .status    (status),
        .evt       (evt),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall)
    );

endmodule
